// ===== hdl/arw_pkg.sv =====
// Shared types and constants for the adaptive read-ahead window block.
package arw_pkg;

	localparam int ADDR_W  = 40;
	localparam int COUNT_W = 7;
	localparam int SLOT_W  = 6;

	typedef enum logic {
		CMD_GET   = 1'b0,
		CMD_CLEAR = 1'b1
	} arw_cmd_t;

	typedef struct packed {
		arw_cmd_t            cmd;
		logic [ADDR_W-1:0]   block_address;
	} arw_req_t;

	typedef struct packed {
		logic                hit;
		logic [ADDR_W-1:0]   fetch_start;
		logic [COUNT_W-1:0]  fetch_count;
		logic [SLOT_W-1:0]   buffer_offset;
	} arw_rsp_t;

endpackage

// ===== hdl/arw_core.sv =====
// Window state registers and the combinational hit/miss decision.
module arw_core #(
	parameter int MIN_FETCH = 1,
	parameter int MAX_FETCH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  arw_pkg::arw_req_t           req,
	input  logic [arw_pkg::ADDR_W-1:0]  device_blocks,
	output logic                        has_rsp,
	output arw_pkg::arw_rsp_t           rsp
);

	localparam int FLOOR    = MIN_FETCH + 1;
	localparam int SIZE_MAX = (MAX_FETCH > FLOOR) ? MAX_FETCH : FLOOR;
	localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
	localparam int THR_W    = SIZE_W + 1;
	localparam int FW       = (SIZE_W > arw_pkg::COUNT_W) ? SIZE_W : arw_pkg::COUNT_W;
	localparam int AW       = arw_pkg::ADDR_W;

	logic [AW-1:0]     begin_q, end_q, last_hit_q;
	logic [SIZE_W-1:0] size_q;

	logic [AW-1:0]     begin_d, end_d, last_hit_d;
	logic [SIZE_W-1:0] size_d;

	logic [AW-1:0]     addr, off, remain, last_off;
	logic              in_window;
	logic [SIZE_W:0]   dbl;
	logic [SIZE_W-1:0] half, fetched;
	logic [THR_W-1:0]  quarter, thr;
	logic [FW-1:0]     fetched_wide;

	assign addr      = req.block_address;
	assign in_window = (addr >= begin_q) && (addr < end_q);
	assign off       = addr - begin_q;
	assign remain    = device_blocks - addr;
	assign last_off  = last_hit_q - begin_q;
	assign dbl       = {size_q, 1'b0};
	assign half      = size_q >> 1;
	assign quarter   = THR_W'(size_q >> 2);
	assign thr       = (quarter << 1) + quarter;

	// An address beyond the device end fetches the full size.
	always_comb begin
		fetched = size_q;
		if (addr <= device_blocks && remain < AW'(size_q)) begin
			fetched = remain[SIZE_W-1:0];
		end
	end

	assign fetched_wide = FW'(fetched);

	always_comb begin
		begin_d    = begin_q;
		end_d      = end_q;
		last_hit_d = last_hit_q;
		size_d     = size_q;
		has_rsp    = 1'b0;
		rsp        = '0;
		if (req.cmd == arw_pkg::CMD_CLEAR) begin
			begin_d = '0;
			end_d   = '0;
		end else if (in_window) begin
			has_rsp = 1'b1;
			if (off >= AW'(half)) begin
				size_d = (dbl < (SIZE_W+1)'(MAX_FETCH)) ? dbl[SIZE_W-1:0]
				                                         : SIZE_W'(MAX_FETCH);
			end
			last_hit_d        = addr;
			rsp.hit           = 1'b1;
			rsp.buffer_offset = off[arw_pkg::SLOT_W-1:0];
		end else begin
			has_rsp = 1'b1;
			end_d   = addr + AW'(fetched);
			// The last hit offset wraps, so a last hit below the window never shrinks.
			if (last_off < AW'(thr)) begin
				size_d = (half > SIZE_W'(FLOOR)) ? half : SIZE_W'(FLOOR);
			end
			begin_d         = addr;
			rsp.fetch_start = addr;
			rsp.fetch_count = fetched_wide[arw_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q    <= '0;
			end_q      <= '0;
			last_hit_q <= '0;
			size_q     <= SIZE_W'(FLOOR);
		end else if (step) begin
			begin_q    <= begin_d;
			end_q      <= end_d;
			last_hit_q <= last_hit_d;
			size_q     <= size_d;
		end
	end

endmodule

// ===== hdl/arw_rsp_reg.sv =====
// Result register that holds a response until the receiver takes it.
module arw_rsp_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  arw_pkg::arw_rsp_t data,
	output logic              valid,
	input  logic              ready,
	output arw_pkg::arw_rsp_t rsp
);

	logic              valid_q;
	arw_pkg::arw_rsp_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign valid = valid_q;
	assign rsp   = data_q;

endmodule

// ===== hdl/adaptive_readahead_window.sv =====
// Top level of the adaptive read-ahead window controller.
//
// Requests arrive on req (valid/ready): a get carries a block address, a
// clear empties the window. Each get produces one response on rsp
// (valid/ready): a hit with the slot in the prefetch buffer, or a miss with
// the start and length of the device read. A clear produces no response.
// cfg_we/cfg_data write the device size in blocks; write it while idle.
//
// A request is captured in an input register, decided combinationally
// against the window registers and lands in the result register. One
// request is taken per cycle unless the response register stalls; the
// window update is a single pass of compares and adds.
// While the response register is full and rsp_ready is low, the input
// register holds and req_ready drops; a clear still passes through.
// Reset empties the window, sets the fetch size to its floor and clears the
// device size; the block takes requests right after reset.
module adaptive_readahead_window #(
	parameter int MIN_FETCH = 1,
	parameter int MAX_FETCH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  arw_pkg::arw_req_t           req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output arw_pkg::arw_rsp_t           rsp,
	input  logic                        cfg_we,
	input  logic [arw_pkg::ADDR_W-1:0]  cfg_data
);

	logic                        valid_s1;
	arw_pkg::arw_req_t           req_s1;
	logic [arw_pkg::ADDR_W-1:0]  dev_blocks_q;
	logic                        advance, has_rsp;
	arw_pkg::arw_rsp_t           rsp_d;

	assign advance   = valid_s1 && (req_s1.cmd == arw_pkg::CMD_CLEAR || !rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			dev_blocks_q <= '0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_we) begin
				dev_blocks_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	arw_core #(
		.MIN_FETCH(MIN_FETCH),
		.MAX_FETCH(MAX_FETCH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.req          (req_s1),
		.device_blocks(dev_blocks_q),
		.has_rsp      (has_rsp),
		.rsp          (rsp_d)
	);

	arw_rsp_reg u_rsp_reg (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (advance && has_rsp),
		.data  (rsp_d),
		.valid (rsp_valid),
		.ready (rsp_ready),
		.rsp   (rsp)
	);

endmodule

// ===== hdl/arw_checker.sv =====
// Port-level checks for the read-ahead window block, bound to the top level.
module arw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input arw_pkg::arw_rsp_t rsp
);

	// A stalled response keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.fetch_count == '0 && rsp.fetch_start == '0)
		else $error("hit response carries a fetch");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.buffer_offset == '0)
		else $error("miss response carries a buffer offset");

	// The block only refuses a request when its response register is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused without a stalled response");

endmodule

bind adaptive_readahead_window arw_checker u_arw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
